FILE: hw/rtl/deq_pkg.sv
// Shared constants for the double-ended queue: command and status codes, field widths, defaults.
package deq_pkg;

    localparam int CMD_W      = 3;
    localparam int PAYLOAD_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int DATA_OUT_W = 32;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DATA  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef logic [STATUS_W-1:0] t_status;

endpackage

FILE: hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: command decode, end pointers, read stage and output register.
// After its request is accepted, a result passes through the read stage and then the output register.
// Throughput: one request per cycle unless stalled; memory takes one write and one read per cycle.
// Reset empties the queue and clears all handshake state; slot contents are not cleared.
// A stalled output holds the read stage, and the input is held off only when both are full.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [deq_pkg::CMD_W-1:0]         i_command,
    input  logic [deq_pkg::PAYLOAD_W-1:0]     i_payload,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [deq_pkg::STATUS_W-1:0]      o_status,
    output logic [deq_pkg::DATA_OUT_W-1:0]    o_data_out
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = AW + 1;

    logic [AW-1:0]         r_head, n_head;
    logic [OW-1:0]         r_occ, n_occ;
    logic                  r_s1_vld;
    t_status               r_s1_status;
    logic                  r_out_vld;
    t_status               r_out_status;
    logic [DATA_OUT_W-1:0] r_out_data;

    logic                  in_acc;
    logic                  out_load;
    logic                  full;
    logic                  empty;
    logic [CW-1:0]         sum;
    logic [CW-1:0]         sum_m1;
    logic [AW-1:0]         back_wr;
    logic [AW-1:0]         back_rd;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    t_status               cmd_status;
    logic [WORD_WIDTH-1:0] rd_data;

    assign out_load = !r_out_vld || i_ready;
    assign o_ready  = !r_s1_vld || out_load;
    assign in_acc   = i_valid && o_ready;

    assign full  = (r_occ == OW'(DEPTH));
    assign empty = (r_occ == '0);

    always_comb begin
        sum      = CW'(r_head) + CW'(r_occ);
        sum_m1   = sum - CW'(1);
        back_wr  = (sum >= CW'(DEPTH)) ? AW'(sum - CW'(DEPTH)) : AW'(sum);
        back_rd  = (sum_m1 >= CW'(DEPTH)) ? AW'(sum_m1 - CW'(DEPTH)) : AW'(sum_m1);
        head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    end

    always_comb begin
        n_head     = r_head;
        n_occ      = r_occ;
        wr_en      = 1'b0;
        wr_addr    = back_wr;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        cmd_status = ST_OK;
        case (i_command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    cmd_status = ST_FULL;
                end else begin
                    wr_en = in_acc;
                    n_occ = r_occ + OW'(1);
                    if (i_command == CMD_PUSH_FRONT) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (empty) begin
                    cmd_status = ST_EMPTY;
                end else begin
                    cmd_status = ST_DATA;
                    rd_en      = in_acc;
                    if (i_command == CMD_POP_BACK || i_command == CMD_PEEK_BACK) begin
                        rd_addr = back_rd;
                    end
                    if (i_command == CMD_POP_FRONT) begin
                        n_head = head_inc;
                        n_occ  = r_occ - OW'(1);
                    end else if (i_command == CMD_POP_BACK) begin
                        n_occ = r_occ - OW'(1);
                    end
                end
            end
            CMD_CLEAR: begin
                n_head = '0;
                n_occ  = '0;
            end
            default: begin
                cmd_status = ST_OK;
            end
        endcase
    end

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (WORD_WIDTH'(i_payload)),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_occ     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_head <= n_head;
                r_occ  <= n_occ;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (out_load) begin
                r_s1_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= cmd_status;
        end
        if (out_load && r_s1_vld) begin
            r_out_status <= r_s1_status;
            r_out_data   <= (r_s1_status == ST_DATA) ? DATA_OUT_W'(rd_data) : '0;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_out_status;
    assign o_data_out = r_out_data;

endmodule

FILE: hw/rtl/deq_ram.sv
// Slot memory of the double-ended queue: one write port and one read port with registered read data.
module deq_ram #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
